@@ sv/ble_pkg.sv @@
// ----------------------------------------------------------------------------
// Battery level estimator package
// Shared field widths, register codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ble_pkg;

	localparam int ADC_W      = 12;
	localparam int WORD_W     = 16;
	localparam int MV_W       = 17;
	localparam int PCT_W      = 7;
	localparam int CHG_W      = 2;
	localparam int MODE_W     = 2;
	localparam int RATIO_W    = 4;
	localparam int CELLS_W    = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int S_DATA_W   = 96;
	localparam int M_DATA_W   = 32;

	localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADC   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_GAUGE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_MON   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_RATIO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_COUNT    = 2'd2;

	localparam logic [CHG_W-1:0] CHG_DISCHARGING = 2'd0;
	localparam logic [CHG_W-1:0] CHG_CHARGING    = 2'd1;
	localparam logic [CHG_W-1:0] CHG_UNKNOWN     = 2'd2;

	typedef struct packed {
		logic load;
		logic mul;
		logic scale;
		logic div_old;
		logic update;
		logic div_new;
		logic emit;
	} ble_cmd_t;

	typedef struct packed {
		logic avg_update;
	} ble_status_t;

endpackage

@@ sv/ble_ctrl.sv @@
// ----------------------------------------------------------------------------
// Battery level estimator controller
// Sequences the datapath steps for one reading and owns both handshakes.
// ----------------------------------------------------------------------------
module ble_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	input  ble_pkg::ble_status_t status,
	output ble_pkg::ble_cmd_t    cmd
);
	import ble_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_MUL     = 3'd1;
	localparam logic [2:0] ST_SCALE   = 3'd2;
	localparam logic [2:0] ST_DIV_OLD = 3'd3;
	localparam logic [2:0] ST_UPDATE  = 3'd4;
	localparam logic [2:0] ST_DIV_NEW = 3'd5;
	localparam logic [2:0] ST_LEVEL   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       m_tvalid_q;
	logic       out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		cmd         = '0;
		cmd.load    = s_tvalid && (state_q == ST_IDLE);
		cmd.mul     = (state_q == ST_MUL);
		cmd.scale   = (state_q == ST_SCALE);
		cmd.div_old = (state_q == ST_DIV_OLD);
		cmd.update  = (state_q == ST_UPDATE);
		cmd.div_new = (state_q == ST_DIV_NEW);
		cmd.emit    = (state_q == ST_LEVEL) && out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_MUL;
			end
			ST_MUL:     state_d = ST_SCALE;
			ST_SCALE: begin
				state_d = status.avg_update ? ST_DIV_OLD : ST_LEVEL;
			end
			ST_DIV_OLD: state_d = ST_UPDATE;
			ST_UPDATE:  state_d = ST_DIV_NEW;
			ST_DIV_NEW: state_d = ST_LEVEL;
			ST_LEVEL: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

@@ sv/ble_datapath.sv @@
// ----------------------------------------------------------------------------
// Battery level estimator datapath
// Configuration registers, voltage scaling, running average and the
// piecewise-linear charge table, stepped by the controller.
// ----------------------------------------------------------------------------
module ble_datapath #(
	parameter int AVERAGE_SAMPLES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ble_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ble_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  ble_pkg::ble_cmd_t                  cmd,
	output ble_pkg::ble_status_t               status,
	input  logic                               in_read_ok,
	input  logic [ble_pkg::S_DATA_W-1:0]       in_data,
	output logic [ble_pkg::MV_W-1:0]           millivolts,
	output logic [ble_pkg::PCT_W-1:0]          percent,
	output logic                               percent_valid,
	output logic [ble_pkg::CHG_W-1:0]          charge_state
);
	import ble_pkg::*;

	localparam int ACC_W = MV_W + $clog2(AVERAGE_SAMPLES);
	localparam int RN_K  = ACC_W + 6;
	localparam longint RN_L = ((longint'(1) << RN_K) + longint'(AVERAGE_SAMPLES) - 1)
		/ longint'(AVERAGE_SAMPLES);
	localparam logic [RN_K-1:0]  RN  = RN_K'(RN_L);
	localparam logic [ACC_W-1:0] N_C = ACC_W'(AVERAGE_SAMPLES);

	function automatic logic [20:0] cell_recip(input logic [CELLS_W-1:0] c);
		logic [20:0] r;
		case (c)
			3'd2:    r = 21'd524288;
			3'd3:    r = 21'd349526;
			3'd4:    r = 21'd262144;
			3'd5:    r = 21'd209716;
			3'd6:    r = 21'd174763;
			3'd7:    r = 21'd149797;
			default: r = 21'd1048576;
		endcase
		return r;
	endfunction

	function automatic logic [PCT_W-1:0] level_pct(input logic [MV_W-1:0] mv);
		logic [7:0]   x6;
		logic [15:0]  p6;
		logic [24:0]  p144;
		logic [MV_W-1:0] d;
		logic [PCT_W-1:0] r;
		d    = '0;
		x6   = '0;
		if (mv >= 17'd3950) begin
			d = mv - 17'd3950;
		end else if (mv >= 17'd3800) begin
			d = mv - 17'd3800;
		end else if (mv >= 17'd3600) begin
			d = mv - 17'd3600;
		end
		x6   = d[7:0];
		p6   = 16'(x6) * 16'd171;
		p144 = 25'(mv[11:0]) * 25'd7282;
		if (mv >= 17'd4100) begin
			r = 7'd100;
		end else if (mv >= 17'd3950) begin
			r = 7'd75 + 7'(p6[15:10]);
		end else if (mv >= 17'd3800) begin
			r = 7'd50 + 7'(p6[15:10]);
		end else if (mv >= 17'd3600) begin
			r = 7'd25 + 7'(d[7:3]);
		end else begin
			r = 7'(p144[24:20]);
		end
		return r;
	endfunction

	logic [MODE_W-1:0]  mode_q;
	logic [RATIO_W-1:0] ratio_q;
	logic [CELLS_W-1:0] cells_q;

	logic                      ok_q;
	logic [ADC_W-1:0]          adc_q;
	logic [WORD_W-1:0]         gv_q;
	logic [WORD_W-1:0]         gsoc_q;
	logic                      dis_q;
	logic [WORD_W-1:0]         bus_q;
	logic signed [WORD_W-1:0]  shunt_q;

	logic [23:0]      pin_prod_q;
	logic [MV_W-1:0]  pack_mv_q;
	logic [15:0]      sample_q;
	logic [MV_W-1:0]  cell_q;
	logic [ACC_W-1:0] acc_q;
	logic             seeded_q;
	logic [ACC_W-1:0] div_q;
	logic [MV_W-1:0]  mv_adc_q;

	logic [MV_W-1:0]           out_mv_q;
	logic [PCT_W-1:0]          out_pct_q;
	logic                      out_pv_q;
	logic [CHG_W-1:0]          out_chg_q;

	logic [18:0]             bus5;
	logic [ADC_W-1:0]        pin_q0;
	logic [ADC_W:0]          pin_r0;
	logic [ADC_W-1:0]        pin_mv;
	logic [RATIO_W-1:0]      ratio_eff;
	logic [CELLS_W-1:0]      cells_eff;
	logic [37:0]             cell_prod;
	logic [ACC_W+RN_K-1:0]   acc_prod;
	logic [ACC_W-1:0]        acc_div;
	logic [ACC_W-1:0]        seed_acc;
	logic [MV_W-1:0]         lvl_mv;
	logic [PCT_W-1:0]        lvl_pct;
	logic [MV_W-1:0]         res_mv;
	logic [PCT_W-1:0]        res_pct;
	logic                    res_pv;
	logic [CHG_W-1:0]        res_chg;

	assign status.avg_update = (mode_q == MODE_ADC) && ok_q;

	assign bus5      = {1'b0, bus_q, 2'b00} + 19'(bus_q);
	assign pin_q0    = pin_prod_q[23:12];
	assign pin_r0    = {1'b0, pin_prod_q[11:0]} + {1'b0, pin_q0};
	assign pin_mv    = (pin_r0 >= 13'd4095) ? pin_q0 + 12'd1 : pin_q0;
	assign ratio_eff = (ratio_q == '0) ? 4'd3 : ratio_q;
	assign cells_eff = (cells_q == '0) ? 3'd1 : cells_q;
	assign cell_prod = 38'(pack_mv_q) * 38'(cell_recip(cells_eff));
	assign acc_prod  = (ACC_W+RN_K)'(acc_q) * (ACC_W+RN_K)'(RN);
	assign acc_div   = acc_prod[ACC_W+RN_K-1:RN_K];
	assign seed_acc  = ACC_W'(ACC_W'(sample_q) * N_C);

	assign lvl_mv  = (mode_q == MODE_ADC) ? (ok_q ? mv_adc_q : '0) : cell_q;
	assign lvl_pct = level_pct(lvl_mv);

	always_comb begin
		res_mv  = '0;
		res_pct = '0;
		res_pv  = 1'b0;
		res_chg = CHG_UNKNOWN;
		case (mode_q)
			MODE_ADC: begin
				res_mv  = lvl_mv;
				res_pct = lvl_pct;
				res_pv  = 1'b1;
			end
			MODE_GAUGE: begin
				if (ok_q) begin
					res_mv  = MV_W'(gv_q);
					res_pct = (gsoc_q > 16'd100) ? 7'd100 : gsoc_q[PCT_W-1:0];
					res_pv  = 1'b1;
					res_chg = dis_q ? CHG_DISCHARGING : CHG_CHARGING;
				end
			end
			MODE_MON: begin
				if (ok_q && (cell_q >= 17'd2800)) begin
					res_mv  = cell_q;
					res_pct = lvl_pct;
					res_pv  = 1'b1;
					res_chg = (shunt_q <= -16'sd8) ? CHG_CHARGING : CHG_DISCHARGING;
				end
			end
			default: begin
				res_mv = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NONE;
			ratio_q  <= 4'd3;
			cells_q  <= 3'd1;
			acc_q    <= '0;
			seeded_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SOURCE_MODE:   mode_q  <= cfg_data[MODE_W-1:0];
					REG_DIVIDER_RATIO: ratio_q <= cfg_data[RATIO_W-1:0];
					REG_CELL_COUNT:    cells_q <= cfg_data[CELLS_W-1:0];
					default:           mode_q  <= mode_q;
				endcase
			end
			if (cmd.update) begin
				acc_q    <= seeded_q ? acc_q - div_q + ACC_W'(sample_q) : seed_acc;
				seeded_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ok_q    <= in_read_ok;
			adc_q   <= in_data[11:0];
			gv_q    <= in_data[27:12];
			gsoc_q  <= in_data[43:28];
			dis_q   <= in_data[44];
			bus_q   <= in_data[75:60];
			shunt_q <= in_data[91:76];
		end
		if (cmd.mul) begin
			pin_prod_q <= 24'(adc_q) * 24'd3100;
			pack_mv_q  <= bus5[18:2];
		end
		if (cmd.scale) begin
			sample_q <= 16'(pin_mv) * 16'(ratio_eff);
			cell_q   <= cell_prod[36:20];
		end
		if (cmd.div_old) begin
			div_q <= acc_div;
		end
		if (cmd.div_new) begin
			mv_adc_q <= MV_W'(acc_div);
		end
		if (cmd.emit) begin
			out_mv_q  <= res_mv;
			out_pct_q <= res_pct;
			out_pv_q  <= res_pv;
			out_chg_q <= res_chg;
		end
	end

	assign millivolts    = out_mv_q;
	assign percent       = out_pct_q;
	assign percent_valid = out_pv_q;
	assign charge_state  = out_chg_q;

endmodule

@@ sv/battery_level_estimator.sv @@
// ----------------------------------------------------------------------------
// Battery level estimator
// Turns one battery reading into millivolts, a percentage and a charge state.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_*      in         one reading per transfer
// m_*      out        one result per transfer
// cfg_*    in         register writes (0 source_mode, 1 divider_ratio, 2 cell_count)
//
// A good ADC divider reading passes load, multiply, scale, three running average
// steps and the level step from its transfer until the next is taken, any other
// reading skips the average; the output register shows the result from the cycle
// before that. Two average steps pass through the shared reciprocal multiplier.
// A result that waits on m_tready holds the controller in its last step.
// Reset clears the configuration to its defaults and empties the average.
// ----------------------------------------------------------------------------
module battery_level_estimator #(
	parameter int AVERAGE_SAMPLES = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// adc_code, gauge_voltage, gauge_soc, gauge_flags, bus_code, shunt_code
	input  logic [ble_pkg::S_DATA_W-1:0]       s_tdata,
	// read_ok
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// millivolts, percent, charge_state
	output logic [ble_pkg::M_DATA_W-1:0]       m_tdata,
	// percent_valid
	output logic                               m_tuser,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ble_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ble_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import ble_pkg::*;

	ble_cmd_t          cmd;
	ble_status_t       status;
	logic [MV_W-1:0]   millivolts;
	logic [PCT_W-1:0]  percent;
	logic [CHG_W-1:0]  charge_state;

	assign cfg_ready = 1'b1;

	ble_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ble_datapath #(
		.AVERAGE_SAMPLES (AVERAGE_SAMPLES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.status        (status),
		.in_read_ok    (s_tuser),
		.in_data       (s_tdata),
		.millivolts    (millivolts),
		.percent       (percent),
		.percent_valid (m_tuser),
		.charge_state  (charge_state)
	);

	assign m_tdata = {6'd0, charge_state, percent, millivolts};

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("reading taken while the previous one was in progress");

	a_pct_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[23:17] == 7'd0))
		else $error("nonzero percent with percent_valid low");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:17] <= 7'd100))
		else $error("percent above 100");

	a_chg_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[25:24] != 2'd3))
		else $error("undefined charge state code");

endmodule

@@ verif/tb_battery_level_estimator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery level estimator testbench
// Runs directed and random battery readings through every source mode under
// changing register settings. Each result is checked field by field against
// a local estimate that tracks the configuration and the running average.
// The two stream sides idle at random, and the result side stalls at times.
// ----------------------------------------------------------------------------
module tb_battery_level_estimator;
	import ble_pkg::*;

	localparam int AVG_SAMPLES = 8;
	localparam int STALL_LIMIT = 5000;
	localparam int TAIL_CYCLES = 16;
	localparam int RX_HOLD_CYCLES = 150;

	typedef enum logic [1:0] {ITEM_READ, ITEM_CFG, ITEM_DRAIN} item_kind_t;

	typedef struct packed {
		logic                     read_ok;
		logic [ADC_W-1:0]         adc_code;
		logic [WORD_W-1:0]        gauge_voltage;
		logic [WORD_W-1:0]        gauge_soc;
		logic [WORD_W-1:0]        gauge_flags;
		logic [WORD_W-1:0]        bus_code;
		logic signed [WORD_W-1:0] shunt_code;
	} reading_t;

	typedef struct packed {
		logic [MV_W-1:0]  millivolts;
		logic [PCT_W-1:0] percent;
		logic             percent_valid;
		logic [CHG_W-1:0] charge_state;
	} level_t;

	typedef struct packed {
		item_kind_t            kind;
		reading_t              reading;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		logic [6:0]            gap_pct;
	} stim_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	stim_item_t pending_items[$];
	level_t expected_levels[$];
	reading_t on_bus;

	logic [MODE_W-1:0] cur_mode = MODE_NONE;
	logic [RATIO_W-1:0] cur_ratio = 4'd3;
	logic [CELLS_W-1:0] cur_cells = 3'd1;
	int unsigned avg_acc = 0;
	logic avg_seeded = 1'b0;

	int mismatch_count = 0;
	int results_seen = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	int stall_cycles = 0;

	battery_level_estimator #(.AVERAGE_SAMPLES(AVG_SAMPLES)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int unsigned soc_from_millivolts(input int unsigned mv);
		if (mv >= 4100)
			return 100;
		else if (mv >= 3950)
			return 75 + 25 * (mv - 3950) / 150;
		else if (mv >= 3800)
			return 50 + 25 * (mv - 3800) / 150;
		else if (mv >= 3600)
			return 25 + 25 * (mv - 3600) / 200;
		else
			return 25 * mv / 3600;
	endfunction

	function automatic level_t estimate_level(input reading_t r);
		level_t res;
		int unsigned mv, pct, ratio, sample, cells, cell_mv;
		logic valid;
		logic [CHG_W-1:0] chg;
		mv = 0;
		pct = 0;
		valid = 1'b0;
		chg = CHG_UNKNOWN;
		case (cur_mode)
			MODE_ADC: begin
				valid = 1'b1;
				if (r.read_ok) begin
					ratio = (cur_ratio == 0) ? 3 : int'(cur_ratio);
					sample = (int'(r.adc_code) * 3100 / 4095) * ratio;
					if (!avg_seeded) begin
						avg_acc = sample * AVG_SAMPLES;
						avg_seeded = 1'b1;
					end else begin
						avg_acc = avg_acc - avg_acc / AVG_SAMPLES + sample;
					end
					mv = avg_acc / AVG_SAMPLES;
				end
				pct = soc_from_millivolts(mv);
			end
			MODE_GAUGE: begin
				if (r.read_ok) begin
					mv = int'(r.gauge_voltage);
					pct = (r.gauge_soc > 100) ? 100 : int'(r.gauge_soc);
					valid = 1'b1;
					chg = r.gauge_flags[0] ? CHG_DISCHARGING : CHG_CHARGING;
				end
			end
			MODE_MON: begin
				if (r.read_ok) begin
					cells = (cur_cells == 0) ? 1 : int'(cur_cells);
					cell_mv = (int'(r.bus_code) * 1250 / 1000) / cells;
					if (cell_mv >= 2800) begin
						mv = cell_mv;
						pct = soc_from_millivolts(cell_mv);
						valid = 1'b1;
						chg = (int'($signed(r.shunt_code)) <= -8) ? CHG_CHARGING
							: CHG_DISCHARGING;
					end
				end
			end
			default: begin
			end
		endcase
		res.millivolts = mv[MV_W-1:0];
		res.percent = pct[PCT_W-1:0];
		res.percent_valid = valid;
		res.charge_state = chg;
		return res;
	endfunction

	function automatic reading_t make_reading(input int ok, input int adc, input int gv,
			input int gsoc, input int gflags, input int bus, input int shunt);
		reading_t r;
		r.read_ok = ok[0];
		r.adc_code = adc[ADC_W-1:0];
		r.gauge_voltage = gv[WORD_W-1:0];
		r.gauge_soc = gsoc[WORD_W-1:0];
		r.gauge_flags = gflags[WORD_W-1:0];
		r.bus_code = bus[WORD_W-1:0];
		r.shunt_code = shunt[WORD_W-1:0];
		return r;
	endfunction

	function automatic reading_t random_reading(input int cells);
		reading_t r;
		int span;
		span = (cells == 0) ? 1 : cells;
		r.read_ok = ($urandom_range(9) != 0);
		r.adc_code = ADC_W'($urandom);
		r.gauge_voltage = ($urandom_range(3) == 0) ? WORD_W'($urandom)
			: WORD_W'($urandom_range(2500, 4500));
		r.gauge_soc = ($urandom_range(3) == 0) ? WORD_W'($urandom)
			: WORD_W'($urandom_range(0, 110));
		r.gauge_flags = WORD_W'($urandom);
		if ($urandom_range(4) == 0)
			r.bus_code = WORD_W'($urandom);
		else
			r.bus_code = WORD_W'(span * $urandom_range(2600, 4300) * 4 / 5
				+ $urandom_range(0, 3));
		if ($urandom_range(1) == 0)
			r.shunt_code = WORD_W'($urandom);
		else
			r.shunt_code = WORD_W'($urandom_range(0, 16) - 12);
		return r;
	endfunction

	task automatic add_read(input reading_t r, input int gap);
		stim_item_t it;
		it = '0;
		it.kind = ITEM_READ;
		it.reading = r;
		it.gap_pct = gap[6:0];
		pending_items.push_back(it);
	endtask

	task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input int value);
		stim_item_t it;
		it = '0;
		it.kind = ITEM_CFG;
		it.reg_index = idx;
		it.reg_value = value[CFG_DATA_W-1:0];
		pending_items.push_back(it);
	endtask

	task automatic add_drain();
		stim_item_t it;
		it = '0;
		it.kind = ITEM_DRAIN;
		pending_items.push_back(it);
	endtask

	task automatic add_setting(input logic [MODE_W-1:0] mode, input int ratio, input int cells);
		add_write(REG_SOURCE_MODE, int'(mode));
		add_write(REG_DIVIDER_RATIO, ratio);
		add_write(REG_CELL_COUNT, cells);
	endtask

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		$display("ERROR result %0d %s: got %0d, expected %0d", results_seen, field, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : driver
		stim_item_t head;
		logic send_read, send_cfg;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			cfg_valid <= 1'b0;
			quiet_cycles = 0;
		end else begin
			send_read = 1'b0;
			send_cfg = 1'b0;
			if (s_tvalid && s_tready)
				expected_levels.push_back(estimate_level(on_bus));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SOURCE_MODE: cur_mode = cfg_data[MODE_W-1:0];
					REG_DIVIDER_RATIO: cur_ratio = cfg_data[RATIO_W-1:0];
					REG_CELL_COUNT: cur_cells = cfg_data[CELLS_W-1:0];
					default: begin
					end
				endcase
			end
			if (expected_levels.size() == 0 && !s_tvalid)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (!((s_tvalid && !s_tready) || (cfg_valid && !cfg_ready))) begin
				if (pending_items.size() != 0) begin
					head = pending_items[0];
					case (head.kind)
						ITEM_READ: begin
							if ($urandom_range(99) >= head.gap_pct) begin
								on_bus = head.reading;
								s_tdata <= {4'b0, head.reading.shunt_code, head.reading.bus_code,
									head.reading.gauge_flags, head.reading.gauge_soc,
									head.reading.gauge_voltage, head.reading.adc_code};
								s_tuser <= head.reading.read_ok;
								send_read = 1'b1;
								void'(pending_items.pop_front());
							end
						end
						ITEM_CFG: begin
							if (quiet_cycles >= 2) begin
								cfg_index <= head.reg_index;
								cfg_data <= head.reg_value;
								send_cfg = 1'b1;
								void'(pending_items.pop_front());
							end
						end
						default: begin
							if (expected_levels.size() == 0)
								void'(pending_items.pop_front());
						end
					endcase
				end
				s_tvalid <= send_read;
				cfg_valid <= send_cfg;
			end
		end
	end

	always @(posedge clk) begin : monitor
		level_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_levels.size() == 0) begin
					report_mismatch("result with nothing pending", m_tdata, 0);
				end else begin
					want = expected_levels.pop_front();
					if (m_tdata[MV_W-1:0] !== want.millivolts)
						report_mismatch("millivolts", 32'(m_tdata[MV_W-1:0]),
							32'(want.millivolts));
					if (m_tdata[MV_W +: PCT_W] !== want.percent)
						report_mismatch("percent", 32'(m_tdata[MV_W +: PCT_W]),
							32'(want.percent));
					if (m_tuser !== want.percent_valid)
						report_mismatch("percent_valid", 32'(m_tuser),
							32'(want.percent_valid));
					if (m_tdata[MV_W+PCT_W +: CHG_W] !== want.charge_state)
						report_mismatch("charge_state", 32'(m_tdata[MV_W+PCT_W +: CHG_W]),
							32'(want.charge_state));
				end
				if (results_seen % 350 == 0)
					hold_left = RX_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >=
					((results_seen >= 450 && results_seen < 650) ? 0 : 25));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("ERROR no transfer for %0d cycles", STALL_LIMIT);
					$display("Mismatches found");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		logic [MODE_W-1:0] mode;
		int ratio, cells, gap;
		arst_n = 1'b0;

		// With no source configured every reading reports unknown.
		add_read(make_reading(1, 4095, 4000, 50, 0, 4000, -100), 25);
		add_read(make_reading(0, 0, 0, 0, 1, 0, 0), 25);

		// ADC divider: a zero ratio falls back to the default, a zero code seeds the average.
		add_setting(MODE_ADC, 0, 1);
		add_read(make_reading(1, 0, 0, 0, 0, 0, 0), 25);
		add_read(make_reading(1, 4095, 0, 0, 0, 0, 0), 25);
		add_read(make_reading(0, 4095, 0, 0, 0, 0, 0), 25);
		add_read(make_reading(1, 4095, 0, 0, 0, 0, 0), 25);
		add_write(REG_DIVIDER_RATIO, 15);
		add_read(make_reading(1, 4095, 0, 0, 0, 0, 0), 25);
		add_read(make_reading(1, 2048, 0, 0, 0, 0, 0), 25);

		// Fuel gauge: clamped charge, flag bit polarity, extreme voltages and a failed read.
		add_setting(MODE_GAUGE, 15, 1);
		add_read(make_reading(1, 0, 65535, 101, 1, 0, 0), 25);
		add_read(make_reading(1, 0, 0, 100, 0, 0, 0), 25);
		add_read(make_reading(1, 0, 3700, 65535, 16'hFFFE, 0, 0), 25);
		add_read(make_reading(0, 4095, 3700, 50, 1, 0, 0), 25);

		// Power monitor: a zero cell count acts as one cell, the pack cutoff, the shunt
		// threshold and each knee of the charge curve.
		add_setting(MODE_MON, 15, 0);
		add_read(make_reading(1, 0, 0, 0, 0, 0, -8), 25);
		add_read(make_reading(1, 0, 0, 0, 0, 65535, -8), 25);
		add_read(make_reading(1, 0, 0, 0, 0, 2240, -7), 25);
		add_read(make_reading(1, 0, 0, 0, 0, 2239, -9), 25);
		add_read(make_reading(1, 0, 0, 0, 0, 3280, -32768), 25);
		add_read(make_reading(1, 0, 0, 0, 0, 3160, 32767), 25);
		add_read(make_reading(1, 0, 0, 0, 0, 3040, 0), 25);
		add_read(make_reading(1, 0, 0, 0, 0, 2880, -8), 25);
		add_read(make_reading(1, 0, 0, 0, 0, 2879, -8), 25);
		add_write(REG_CELL_COUNT, 7);
		add_read(make_reading(1, 0, 0, 0, 0, 65535, -1), 25);

		for (int p = 0; p < 10; p++) begin
			case (p)
				0, 3, 7, 9: mode = MODE_ADC;
				1, 6: mode = MODE_GAUGE;
				5: mode = MODE_NONE;
				default: mode = MODE_MON;
			endcase
			ratio = (p == 0) ? 1 : (p == 3) ? 15 : (p == 7) ? 0 : $urandom_range(0, 15);
			cells = (p == 2) ? 7 : (p == 4) ? 0 : (p == 8) ? 4 : $urandom_range(0, 7);
			gap = (p == 4) ? 0 : 25;
			add_setting(mode, ratio, cells);
			for (int k = 0; k < 105; k++) begin
				add_read(random_reading(cells), gap);
				if (k == 50 && (p == 2 || p == 6))
					add_drain();
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_items.size() != 0 || s_tvalid || cfg_valid || expected_levels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
